FILE: rtl/tnsf_pkg.sv
`default_nettype none

package tnsf_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
  } res_t;

  localparam int SlotCount = 5;

  // one accepted byte's worth of results, slot 0 first
  typedef struct packed {
    logic [SlotCount-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } cmd_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam int StopCount = 9;

  localparam logic [7:0] STOP_CHR [StopCount][3] = '{
    '{8'h74, 8'h68, 8'h65},  // the
    '{8'h61, 8'h00, 8'h00},  // a
    '{8'h61, 8'h6e, 8'h00},  // an
    '{8'h69, 8'h73, 8'h00},  // is
    '{8'h61, 8'h72, 8'h65},  // are
    '{8'h74, 8'h6f, 8'h00},  // to
    '{8'h6f, 8'h66, 8'h00},  // of
    '{8'h61, 8'h6e, 8'h64},  // and
    '{8'h69, 8'h6e, 8'h00}   // in
  };

  localparam logic [1:0] STOP_LEN [StopCount] = '{
    2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2
  };

  function automatic logic is_stopword(input logic [2:0][7:0] w, input logic [1:0] n);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int i = 0; i < StopCount; i++) begin
      eq = (STOP_LEN[i] == n);
      for (int k = 0; k < 3; k++) begin
        if ((k < int'(n)) && (STOP_CHR[i][k] != w[k])) begin
          eq = 1'b0;
        end
      end
      hit = hit | eq;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/text_normalizer_stopword_filter.sv
// Results pass through the queue memory and then the back end entry register.
// Throughput: one input byte per cycle while the queue has room; the back end emits one
// result per cycle while res_ready is high, so it holds a byte until all its results go.
// Reset: synchronous rst clears word state, queue pointers, the output stage and
// remove_stopwords; held word characters are not cleared.
`default_nettype none

module text_normalizer_stopword_filter
  import tnsf_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res_item,
  input  wire logic cfg_we,
  input  wire logic cfg_data
);

  logic remove_stopwords;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t push_data;
  cmd_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      remove_stopwords <= 1'b0;
    end else if (cfg_we) begin
      remove_stopwords <= cfg_data;
    end
  end

  tnsf_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .remove_stopwords (remove_stopwords),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (push_data)
  );

  tnsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  tnsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue push while full");

  a_marker_is_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.out_valid) |-> res_item.out_end)
    else $error("empty result without end mark");

  a_char_class: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.out_valid) |->
      (((res_item.out_byte >= 8'h61) && (res_item.out_byte <= 8'h7a)) ||
       ((res_item.out_byte >= 8'h30) && (res_item.out_byte <= 8'h39)) ||
       (res_item.out_byte == ChSpace)))
    else $error("output byte outside normalized set");

  a_space_not_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.out_valid && (res_item.out_byte == ChSpace)) |->
      !res_item.out_end)
    else $error("trailing space emitted");

endmodule

`default_nettype wire

FILE: rtl/tnsf_front.sv
`default_nettype none

module tnsf_front
  import tnsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  input  wire logic remove_stopwords,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_data
);

  logic [2:0][7:0] word_buf;
  logic [2:0][7:0] word_buf_next;
  logic [1:0]      buf_cnt;
  logic [1:0]      buf_cnt_next;
  logic            streaming;
  logic            streaming_next;
  logic            sep_owed;
  logic            sep_owed_next;

  logic            accept;
  logic [7:0]      lc;
  logic            word_char;
  logic            path_a;
  logic            path_b;
  logic            path_c;
  logic [2:0][7:0] cand;
  logic [1:0]      cand_n;
  logic            drop;
  logic            emit_end;
  logic            sp;
  logic [1:0]      nh;
  logic            chr;
  logic [2:0]      num;
  logic [2:0]      chr_pos;
  logic [SlotCount-1:0][7:0] slots;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    lc = ((in_item.in_byte >= 8'h41) && (in_item.in_byte <= 8'h5a)) ?
         (in_item.in_byte + 8'h20) : in_item.in_byte;
    word_char = ((lc >= 8'h61) && (lc <= 8'h7a)) || ((lc >= 8'h30) && (lc <= 8'h39));

    path_b = word_char && remove_stopwords && !streaming && (buf_cnt != 2'd3);
    path_a = word_char && !path_b;
    path_c = !word_char;

    // word as it stands when it ends on this byte
    cand = word_buf;
    for (int k = 0; k < 3; k++) begin
      if (path_b && (buf_cnt == 2'(k))) begin
        cand[k] = lc;
      end
    end
    cand_n = path_b ? (buf_cnt + 2'd1) : buf_cnt;
    drop   = remove_stopwords && is_stopword(cand, cand_n);

    emit_end = (path_c || (path_b && in_item.in_last)) && (cand_n != 2'd0) && !drop;
    sp       = path_a ? (!streaming && sep_owed) : (emit_end && sep_owed);
    nh       = (path_a || emit_end) ? buf_cnt : 2'd0;
    chr      = path_a || (path_b && emit_end);
    chr_pos  = {2'b00, sp} + {1'b0, nh};
    num      = chr_pos + {2'b00, chr};

    slots[0] = sp ? ChSpace : word_buf[0];
    slots[1] = sp ? word_buf[0] : word_buf[1];
    slots[2] = sp ? word_buf[1] : word_buf[2];
    slots[3] = word_buf[2];
    slots[4] = 8'h00;
    for (int i = 0; i < SlotCount; i++) begin
      if (chr && (chr_pos == 3'(i))) begin
        slots[i] = lc;
      end
    end

    word_buf_next  = word_buf;
    buf_cnt_next   = buf_cnt;
    streaming_next = streaming;
    sep_owed_next  = sep_owed;
    if (path_a) begin
      buf_cnt_next   = 2'd0;
      streaming_next = 1'b1;
      sep_owed_next  = 1'b0;
    end
    if (path_b) begin
      word_buf_next = cand;
      buf_cnt_next  = buf_cnt + 2'd1;
    end
    if (path_c) begin
      if (buf_cnt != 2'd0) begin
        buf_cnt_next = 2'd0;
        if (!drop) begin
          sep_owed_next = 1'b1;
        end
      end else if (streaming) begin
        streaming_next = 1'b0;
        sep_owed_next  = 1'b1;
      end
    end
    if (in_item.in_last) begin
      buf_cnt_next   = 2'd0;
      streaming_next = 1'b0;
      sep_owed_next  = 1'b0;
    end
  end

  assign q_push       = accept && ((num != 3'd0) || in_item.in_last);
  assign q_data.bytes = slots;
  assign q_data.cnt   = num;
  assign q_data.last  = in_item.in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt   <= 2'd0;
      streaming <= 1'b0;
      sep_owed  <= 1'b0;
    end else if (accept) begin
      buf_cnt   <= buf_cnt_next;
      streaming <= streaming_next;
      sep_owed  <= sep_owed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_buf <= word_buf_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tnsf_queue.sv
`default_nettype none

module tnsf_queue
  import tnsf_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  output logic      q_valid,
  output cmd_t      q_data,
  input  wire logic pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : (wr_ptr + PtrW'(1));
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : (rd_ptr + PtrW'(1));
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tnsf_back.sv
`default_nettype none

module tnsf_back
  import tnsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cmd_t q_data,
  output logic      q_pop,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res_item
);

  cmd_t       ent;
  logic       ent_valid;
  logic [2:0] pos;
  logic       ent_done;
  logic       free;

  assign ent_done = (ent.cnt == 3'd0) || (pos == (ent.cnt - 3'd1));
  assign free     = !ent_valid || (res_ready && ent_done);
  assign q_pop    = q_valid && free;

  assign res_valid          = ent_valid;
  assign res_item.out_byte  = (ent.cnt == 3'd0) ? 8'h00 : ent.bytes[pos];
  assign res_item.out_valid = (ent.cnt != 3'd0);
  assign res_item.out_end   = ent.last && ent_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (free) begin
      ent_valid <= q_valid;
      pos       <= 3'd0;
    end else if (res_ready) begin
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_data;
    end
  end

endmodule

`default_nettype wire
